>>> rtl/kalman_position_velocity_1d_assert.svh
// assertion macros for the kalman position velocity block
`ifndef KALMAN_POSITION_VELOCITY_1D_ASSERT_SVH
`define KALMAN_POSITION_VELOCITY_1D_ASSERT_SVH
`ifndef SYNTHESIS
`define KPV_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KPV_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define KPV_ASSERT_IMP(label, clk, rst_n, a, c)
`define KPV_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/kpv_pkg.sv
// shared constants and types for the kalman position velocity block
package kpv_pkg;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdWidth = 2 * WordWidth + 2;
  localparam int unsigned CntWidth = $clog2(ProdWidth + 1);

  localparam logic [0:0] CfgProcessNoise = 1'b0;
  localparam logic [0:0] CfgMeasurementNoise = 1'b1;

  typedef logic signed [WordWidth-1:0] word_t;

  // request to the multiply-divide unit
  typedef struct packed {
    logic                 start;
    logic [WordWidth:0]   a;
    logic [WordWidth:0]   b;
    logic [WordWidth:0]   c;
  } md_req_t;

  typedef struct packed {
    logic                 done;
    word_t                res;
  } md_rsp_t;

  function automatic word_t sat_w(input logic signed [WordWidth+1:0] v);
    logic signed [WordWidth+1:0] hi;
    logic signed [WordWidth+1:0] lo;
    hi = {3'b000, {(WordWidth-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return word_t'(hi[WordWidth-1:0]);
    else if (v < lo) return word_t'(lo[WordWidth-1:0]);
    else return word_t'(v[WordWidth-1:0]);
  endfunction
endpackage

>>> rtl/kalman_position_velocity_1d.sv
// Two-state constant-velocity Kalman filter with a scalar position measurement.
// One item takes 14 passes through the shared multiply-divide unit when the
// correction runs and 9 when it is skipped. The five passes that divide by the
// innovation variance run the 66-bit bit-serial restoring divide; the nine that
// scale by 2^16 take the quotient straight from the product. The result waits
// in an output register and the next item is taken once it has gone.
`include "kalman_position_velocity_1d_assert.svh"
module kalman_position_velocity_1d (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  measurement_i,
  input  logic [15:0]         time_step_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  position_estimate_o,
  output logic signed [31:0]  velocity_estimate_o
);
  localparam int unsigned W = kpv_pkg::WordWidth;
  typedef kpv_pkg::word_t word_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT = 4'b1000
  } st_e;

  // operation codes of the sequence
  typedef enum logic [3:0] {
    OP_Z, OP_Q, OP_R, OP_PP, OP_T00, OP_T01, OP_A00,
    OP_K0, OP_K1, OP_C00, OP_C01, OP_C11, OP_O0, OP_O1
  } op_e;

  st_e st_q, st_d;
  op_e op_q, op_d;
  logic [31:0] q_q, r_q;
  word_t pos_q, vel_q, p00_q, p01_q, p11_q;
  word_t z_q, qf_q, rf_q, pp_q, t00_q, t01_q, a00_q, a11_q, y_q, s_q;
  word_t out0_q;
  logic signed [31:0] opos_q, ovel_q;
  logic signed [31:0] mz_q;
  logic [15:0] dt_q;
  kpv_pkg::md_req_t req;
  kpv_pkg::md_rsp_t rsp;
  logic signed [W+1:0] ext_res;
  logic done_item;

  function automatic logic signed [W+1:0] ex(input word_t v);
    return {{2{v[W-1]}}, v};
  endfunction

  function automatic logic [W:0] sx(input word_t v);
    return {v[W-1], v};
  endfunction

  kpv_muldiv u_md (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  localparam logic [W:0] Unity = (W+1)'(65536);
  localparam logic [W:0] OneW = (W+1)'(1) << kpv_pkg::FracBits;

  always_comb begin
    req.start = (st_q == S_ISSUE);
    req.a = '0;
    req.b = '0;
    req.c = Unity;
    case (op_q)
      OP_Z: begin req.a = (W+1)'(mz_q); req.b = OneW; end
      OP_Q: begin req.a = {1'b0, q_q}; req.b = OneW; end
      OP_R: begin req.a = {1'b0, r_q}; req.b = OneW; end
      OP_PP: begin req.a = sx(vel_q); req.b = (W+1)'(dt_q); end
      OP_T00: begin req.a = sx(p01_q); req.b = (W+1)'(dt_q); end
      OP_T01: begin req.a = sx(p11_q); req.b = (W+1)'(dt_q); end
      OP_A00: begin req.a = sx(t01_q); req.b = (W+1)'(dt_q); end
      OP_K0: begin req.a = sx(a00_q); req.b = sx(y_q); req.c = sx(s_q); end
      OP_K1: begin req.a = sx(t01_q); req.b = sx(y_q); req.c = sx(s_q); end
      OP_C00: begin req.a = sx(a00_q); req.b = sx(rf_q); req.c = sx(s_q); end
      OP_C01: begin req.a = sx(t01_q); req.b = sx(rf_q); req.c = sx(s_q); end
      OP_C11: begin req.a = sx(t01_q); req.b = sx(t01_q); req.c = sx(s_q); end
      OP_O0: begin req.a = sx(pos_q); req.b = (W+1)'(65536); req.c = OneW; end
      OP_O1: begin req.a = sx(vel_q); req.b = (W+1)'(65536); req.c = OneW; end
      default: ;
    endcase
  end

  assign ext_res = ex(rsp.res);
  assign done_item = (st_q == S_WAIT) && rsp.done && (op_q == OP_O1);

  always_comb begin
    st_d = st_q;
    op_d = op_q;
    case (st_q)
      S_IDLE: if (in_valid_i) begin st_d = S_ISSUE; op_d = OP_Z; end
      S_ISSUE: st_d = S_WAIT;
      S_WAIT: begin
        if (rsp.done) begin
          st_d = S_ISSUE;
          case (op_q)
            OP_A00: op_d = (kpv_pkg::sat_w(ex(kpv_pkg::sat_w(ex(t00_q) + ext_res
                            + ex(qf_q))) + ex(rf_q)) > 0) ? OP_K0 : OP_O0;
            OP_C11: op_d = OP_O0;
            OP_O1: st_d = S_OUT;
            default: op_d = op_e'(op_q + 1'b1);
          endcase
        end
      end
      S_OUT: if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      op_q <= OP_Z;
      q_q <= 32'd655;
      r_q <= 32'd65536;
      pos_q <= '0;
      vel_q <= '0;
      p00_q <= word_t'(OneW[W-1:0]);
      p01_q <= '0;
      p11_q <= word_t'(OneW[W-1:0]);
    end else begin
      st_q <= st_d;
      op_q <= op_d;
      if (cfg_we_i && cfg_index_i == kpv_pkg::CfgProcessNoise) q_q <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == kpv_pkg::CfgMeasurementNoise) r_q <= cfg_data_i;
      if (st_q == S_WAIT && rsp.done) begin
        case (op_q)
          OP_A00: begin
            p00_q <= kpv_pkg::sat_w(ex(t00_q) + ext_res + ex(qf_q));
            p01_q <= t01_q;
            p11_q <= a11_q;
            pos_q <= pp_q;
          end
          OP_K0: pos_q <= kpv_pkg::sat_w(ex(pp_q) + ext_res);
          OP_K1: vel_q <= kpv_pkg::sat_w(ex(vel_q) + ext_res);
          OP_C00: p00_q <= rsp.res;
          OP_C01: p01_q <= rsp.res;
          OP_C11: p11_q <= kpv_pkg::sat_w(ex(a11_q) - ext_res);
          default: ;
        endcase
      end
    end
  end

  // datapath temporaries, no reset
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      mz_q <= measurement_i;
      dt_q <= time_step_i;
    end
    if (st_q == S_WAIT && rsp.done) begin
      case (op_q)
        OP_Z: z_q <= rsp.res;
        OP_Q: begin
          qf_q <= rsp.res;
          a11_q <= kpv_pkg::sat_w(ex(p11_q) + ext_res);
        end
        OP_R: rf_q <= rsp.res;
        OP_PP: begin
          pp_q <= kpv_pkg::sat_w(ex(pos_q) + ext_res);
          y_q <= kpv_pkg::sat_w(ex(z_q) - ex(kpv_pkg::sat_w(ex(pos_q) + ext_res)));
        end
        OP_T00: t00_q <= kpv_pkg::sat_w(ex(p00_q) + ext_res);
        OP_T01: t01_q <= kpv_pkg::sat_w(ex(p01_q) + ext_res);
        OP_A00: begin
          a00_q <= kpv_pkg::sat_w(ex(t00_q) + ext_res + ex(qf_q));
          s_q <= kpv_pkg::sat_w(ex(kpv_pkg::sat_w(ex(t00_q) + ext_res + ex(qf_q)))
                 + ex(rf_q));
        end
        OP_O0: out0_q <= rsp.res;
        default: ;
      endcase
    end
    if (done_item) begin
      opos_q <= out0_q;
      ovel_q <= rsp.res;
    end
  end

  assign in_stall_o = (st_q != S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign position_estimate_o = opos_q;
  assign velocity_estimate_o = ovel_q;

  `KPV_ASSERT_NXT(a_out_after_last, clk_i, rst_ni, done_item, out_valid_o)
  `KPV_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, out_valid_o, in_stall_o)
  `KPV_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(position_estimate_o))
endmodule

>>> rtl/kpv_muldiv.sv
// shared multiply-divide unit: round(a*b/c) saturated, one quotient bit a cycle
`include "kalman_position_velocity_1d_assert.svh"
module kpv_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kpv_pkg::md_req_t req_i,
  output kpv_pkg::md_rsp_t rsp_o
);
  localparam int unsigned W = kpv_pkg::WordWidth;
  localparam int unsigned PW = kpv_pkg::ProdWidth;
  // dt scaling and the format changes all divide by 2^16, which is a shift
  localparam int unsigned Sh = 16;
  localparam logic [W:0] ShiftDiv = (W+1)'(1) << Sh;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } md_state_e;

  md_state_e state_q, state_d;
  logic [PW-1:0] num_q, num_d;
  logic [W:0] rem_q, rem_d;
  logic [W+1:0] quo_q, quo_d;
  logic [W:0] ua_q, ub_q, uc_q, ua_d, ub_d, uc_d;
  logic neg_q, neg_d, over_q, over_d;
  logic [kpv_pkg::CntWidth-1:0] cnt_q, cnt_d;
  logic [W+1:0] rsh;
  logic [W+1:0] quo_r;
  logic [W+1:0] limit;
  logic [W+1:0] mag;
  logic [W+1:0] twice;
  logic [PW-1:0] prod;
  kpv_pkg::word_t res_q, res_d;
  logic done_q, done_d;

  always_comb begin
    state_d = state_q;
    num_d = num_q;
    rem_d = rem_q;
    quo_d = quo_q;
    ua_d = ua_q;
    ub_d = ub_q;
    uc_d = uc_q;
    neg_d = neg_q;
    over_d = over_q;
    cnt_d = cnt_q;
    res_d = res_q;
    done_d = 1'b0;
    rsh = {rem_q, num_q[PW-1]};
    twice = {rem_q, 1'b0};
    quo_r = quo_q;
    limit = '0;
    mag = '0;
    prod = '0;
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.a[W] ^ req_i.b[W];
          ua_d = req_i.a[W] ? (~req_i.a + 1'b1) : req_i.a;
          ub_d = req_i.b[W] ? (~req_i.b + 1'b1) : req_i.b;
          uc_d = req_i.c;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod = PW'(ua_q) * PW'(ub_q);
        num_d = prod;
        rem_d = '0;
        quo_d = '0;
        over_d = 1'b0;
        cnt_d = kpv_pkg::CntWidth'(PW);
        if (uc_q == ShiftDiv) begin
          // power-of-two divisor: quotient and remainder straight from the product
          quo_d = prod[Sh +: W+2];
          rem_d = (W+1)'(prod[Sh-1:0]);
          over_d = |prod[PW-1:Sh+W+2];
          cnt_d = '0;
        end
        state_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q != '0) begin
          num_d = {num_q[PW-2:0], 1'b0};
          if (quo_q[W+1]) over_d = 1'b1;
          quo_d = {quo_q[W:0], 1'b0};
          if (rsh >= {1'b0, uc_q}) begin
            rem_d = (W+1)'(rsh - {1'b0, uc_q});
            quo_d[0] = 1'b1;
          end else begin
            rem_d = rsh[W:0];
          end
          cnt_d = cnt_q - 1'b1;
        end else begin
          limit = {3'b000, {(W-1){1'b1}}} + (W+2)'(neg_q);
          if (!over_q && twice >= {1'b0, uc_q}) quo_r = quo_q + 1'b1;
          mag = (over_q || quo_q > limit || quo_r > limit) ? limit : quo_r;
          res_d = neg_q ? kpv_pkg::word_t'(~mag[W-1:0] + 1'b1)
                        : kpv_pkg::word_t'(mag[W-1:0]);
          if (uc_q[W] || uc_q == '0) res_d = '0;
          done_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ua_q <= ua_d;
    ub_q <= ub_d;
    uc_q <= uc_d;
    neg_q <= neg_d;
    over_q <= over_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res = res_q;

  `KPV_ASSERT_NXT(a_md_done_from_div, clk_i, rst_ni, rsp_o.done, state_q == S_IDLE)
  `KPV_ASSERT_NXT(a_md_start_mul, clk_i, rst_ni, state_q == S_IDLE && req_i.start,
    state_q == S_MUL)
  `KPV_ASSERT_IMP(a_md_cnt_range, clk_i, rst_ni, state_q == S_DIV,
    cnt_q <= kpv_pkg::CntWidth'(PW))
endmodule

>>> sim/tb.sv
// self-checking testbench for the two-state position/velocity kalman filter
module tb;
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = kpv_pkg::CfgProcessNoise;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] measurement_i = '0;
  logic [15:0]        time_step_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] position_estimate_o;
  logic signed [31:0] velocity_estimate_o;

  kalman_position_velocity_1d u_dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } estimate_t;

  estimate_t estimate_q[$];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  localparam longint unsigned CycleLimit = 12_000_000;

  // filter copy kept by the testbench
  longint noise_q, noise_r;
  longint x_pos, x_vel, p00, p01, p11;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round(a*b/c), ties away from zero, saturated to bits
  function automatic longint mul_div_round(longint a, longint b, longint c, int bits);
    logic [127:0] ua, ub, prod, quo, rm;
    logic         neg;
    longint       lim;
    if (c <= 0) return 0;
    neg = (a < 0) != (b < 0);
    ua = 128'(a < 0 ? -a : a);
    ub = 128'(b < 0 ? -b : b);
    prod = ua * ub;
    quo = prod / 128'(c);
    rm = prod % 128'(c);
    if (2 * rm >= 128'(c)) quo = quo + 1;
    lim = (64'sd1 << (bits - 1)) - (neg ? 0 : 1);
    if (quo > 128'(lim)) quo = 128'(lim);
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic longint by_dt(longint a, longint dt);
    return mul_div_round(a, dt, 65536, 32);
  endfunction

  function automatic estimate_t filter_update(logic signed [31:0] meas, logic [15:0] dt_raw);
    longint    z, qf, rf, dt, pp, t00, t01, a00, a01, a11, y, s;
    estimate_t e;
    dt = longint'(dt_raw);
    z = longint'(meas);
    qf = sat32(noise_q);
    rf = sat32(noise_r);
    pp = sat32(x_pos + by_dt(x_vel, dt));
    t00 = sat32(p00 + by_dt(p01, dt));
    t01 = sat32(p01 + by_dt(p11, dt));
    a00 = sat32(t00 + by_dt(t01, dt) + qf);
    a01 = t01;
    a11 = sat32(p11 + qf);
    y = sat32(z - pp);
    s = sat32(a00 + rf);
    if (s > 0) begin
      x_pos = sat32(pp + mul_div_round(a00, y, s, 32));
      x_vel = sat32(x_vel + mul_div_round(a01, y, s, 32));
      p00 = mul_div_round(a00, rf, s, 32);
      p01 = mul_div_round(a01, rf, s, 32);
      p11 = sat32(a11 - mul_div_round(a01, a01, s, 32));
    end else begin
      // no correction when the innovation variance is not positive
      x_pos = pp;
      p00 = a00;
      p01 = a01;
      p11 = a11;
    end
    e.pos = x_pos[31:0];
    e.vel = x_vel[31:0];
    return e;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < 30) begin
        n = gap_len();
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    estimate_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (estimate_q.size() == 0) begin
        $error("result with no expected estimate");
        errors++;
      end else begin
        e = estimate_q.pop_front();
        if (position_estimate_o !== e.pos) begin
          $error("position_estimate expected %0d actual %0d", e.pos, position_estimate_o);
          errors++;
        end
        if (velocity_estimate_o !== e.vel) begin
          $error("velocity_estimate expected %0d actual %0d", e.vel, velocity_estimate_o);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic signed [31:0] meas, logic [15:0] dt, bit no_gap = 0);
    int n;
    n = no_gap ? 0 : gap_len();
    // valid drops between items, also when no_gap is set
    repeat (n + 1) @(negedge clk_i);
    measurement_i <= meas;
    time_step_i <= dt;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    estimate_q.push_back(filter_update(meas, dt));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (estimate_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == kpv_pkg::CfgProcessNoise) noise_q = longint'(value);
    else noise_r = longint'(value);
  endtask

  task automatic test_directed();
    send_item(32'sh7fffffff, 16'hffff);
    send_item(-32'sh80000000, 16'hffff);
    send_item(32'sd0, 16'd0);
    send_item(32'sd65536, 16'd0);
    send_item(-32'sd1, 16'd1);
    send_item(32'sh55555555, 16'haaaa);
    send_item(32'shaaaaaaaa, 16'h5555);
  endtask

  task automatic test_noise_extremes();
    // q and r at the top saturate the covariance
    write_reg(kpv_pkg::CfgProcessNoise, 32'hffffffff);
    write_reg(kpv_pkg::CfgMeasurementNoise, 32'hffffffff);
    send_item(32'sh7fffffff, 16'hffff);
    send_item(-32'sh80000000, 16'hffff);
    send_item(32'sd1000, 16'h8000);
    // r zero collapses the position variance; then no correction at all
    write_reg(kpv_pkg::CfgProcessNoise, 32'd0);
    write_reg(kpv_pkg::CfgMeasurementNoise, 32'd0);
    send_item(32'sd12345, 16'd0);
    send_item(32'sd99999, 16'd0);
    send_item(-32'sd4321, 16'd0);
    send_item(32'sd500, 16'hffff);
    write_reg(kpv_pkg::CfgProcessNoise, 32'hffffffff);
    send_item(32'sd7, 16'd100);
    write_reg(kpv_pkg::CfgMeasurementNoise, 32'd1);
    send_item(-32'sd7, 16'd100);
  endtask

  task automatic test_random_tracking(int items);
    longint truth, speed;
    logic signed [31:0] meas;
    logic [15:0] dt;
    truth = longint'($urandom_range(0, 200000)) - 100000;
    speed = longint'($urandom_range(0, 400000)) - 200000;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 9))
        0: dt = 16'($urandom);
        1: dt = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'd0;
        default: dt = 16'($urandom_range(300, 6000));
      endcase
      truth = truth + ((speed * longint'(dt)) >>> 16);
      if ($urandom_range(0, 19) == 0) meas = $urandom;
      else meas = 32'(sat32(truth + longint'($urandom_range(0, 20000)) - 10000));
      send_item(meas, dt);
      if (i == items / 2) wait_drained();
    end
  endtask

  initial begin
    noise_q = 655;
    noise_r = 65536;
    x_pos = 0;
    x_vel = 0;
    p00 = 65536;
    p01 = 0;
    p11 = 65536;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_noise_extremes();
    write_reg(kpv_pkg::CfgProcessNoise, 32'd655);
    write_reg(kpv_pkg::CfgMeasurementNoise, 32'd65536);
    test_random_tracking(500);
    write_reg(kpv_pkg::CfgProcessNoise, $urandom);
    write_reg(kpv_pkg::CfgMeasurementNoise, $urandom_range(1, 1 << 24));
    test_random_tracking(400);
    write_reg(kpv_pkg::CfgProcessNoise, $urandom_range(0, 50));
    write_reg(kpv_pkg::CfgMeasurementNoise, $urandom);
    test_random_tracking(450);
    wait_drained();
    repeat (1000) @(negedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
